### hdl/rsp_pkg.sv
// Shared types, character codes and numeric limits for the RESP2 reply parser.
// Used by rsp_parse, rsp_out_stage, the top level and the checkers; depends on nothing.
`timescale 1ns / 1ps

package rsp_pkg;

  localparam int LenBitsDef = 32;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [63:0] IntPosLimit = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] IntNegLimit = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ArrLimit    = 64'h0000_0000_FFFF_FFFF;

  localparam logic [63:0] IntPosDiv = IntPosLimit / 64'd10;
  localparam logic [3:0]  IntPosMod = 4'(IntPosLimit % 64'd10);
  localparam logic [63:0] IntNegDiv = IntNegLimit / 64'd10;
  localparam logic [3:0]  IntNegMod = 4'(IntNegLimit % 64'd10);
  localparam logic [63:0] ArrDiv    = ArrLimit / 64'd10;
  localparam logic [3:0]  ArrMod    = 4'(ArrLimit % 64'd10);

  typedef enum logic [4:0] {
    PH_IDLE, PH_SIMPLE_TXT, PH_SIMPLE_LF, PH_ERR_TXT, PH_INT_SIGN, PH_INT_DIG,
    PH_BULK_DIG, PH_BULK_HDR_LF, PH_BULK_DATA, PH_BULK_END_CR, PH_BULK_END_LF,
    PH_NULL_ONE, PH_NULL_CR, PH_NULL_LF, PH_ARR_DIG, PH_ARR_LF
  } rsp_phase_e;

  typedef enum logic [1:0] {
    KIND_DATA, KIND_DONE, KIND_ARRAY_HDR, KIND_FAULT
  } rsp_kind_e;

  typedef enum logic [2:0] {
    VT_SIMPLE, VT_ERROR, VT_INTEGER, VT_BULK, VT_NULL, VT_ARRAY
  } rsp_vtype_e;

  typedef enum logic [2:0] {
    FLT_NONE, FLT_BAD_TYPE, FLT_BAD_DIGIT, FLT_NO_CRLF, FLT_OVERFLOW, FLT_EMPTY
  } rsp_fault_e;

  typedef struct packed {
    rsp_kind_e   kind;
    rsp_vtype_e  vtype;
    logic [7:0]  data;
    logic [63:0] number;
    logic        inarr;
    logic        done;
    rsp_fault_e  fcode;
  } rsp_res_t;

endpackage

### hdl/rsp_in_stage.sv
// Input register: captures one received byte and holds it until the parse step takes it.
// Depends on nothing beyond its ports.
`timescale 1ns / 1ps

module rsp_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       advance_i,
  output logic       vld_o,
  output logic [7:0] byte_o
);

  logic       vld_q;
  logic [7:0] byte_q;

  assign in_ready_o = !vld_q || advance_i;
  assign vld_o      = vld_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

### hdl/rsp_parse.sv
// Parse step: reply state registers and the single-pass next-state and result logic.
// Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_parse import rsp_pkg::*; #(
  parameter int LEN_BITS = LenBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic [7:0] byte_i,
  output logic       res_vld_o,
  output rsp_res_t   res_o
);

  localparam logic [63:0] LenLimit = (LEN_BITS >= 64) ? {64{1'b1}} :
                                     ((64'd1 << LEN_BITS) - 64'd1);
  localparam logic [63:0] LenDiv = LenLimit / 64'd10;
  localparam logic [3:0]  LenMod = 4'(LenLimit % 64'd10);

  rsp_phase_e          phase_q, phase_d;
  rsp_vtype_e          cur_type_q, cur_type_d;
  logic                negative_q, negative_d;
  logic [63:0]         accum_q, accum_d;
  logic                seen_q, seen_d;
  logic [LEN_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [31:0]         elems_left_q, elems_left_d;
  logic                in_array_q, in_array_d;
  logic                swallow_q, swallow_d;

  logic        is_dig, is_eol, skip;
  logic [3:0]  dval;
  logic [63:0] lim_div, acc_next;
  logic [3:0]  lim_mod;
  logic        ovf;
  logic        flt, fin;
  rsp_fault_e  fcode;
  rsp_vtype_e  fin_type;
  logic [63:0] fin_num;

  assign is_dig   = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_eol   = (byte_i == CH_CR) || (byte_i == CH_LF);
  assign dval     = 4'(byte_i - CH_ZERO);
  assign skip     = swallow_q && (byte_i == CH_LF);
  assign acc_next = (accum_q << 3) + (accum_q << 1) + {60'd0, dval};

  always_comb begin
    unique case (phase_q)
      PH_BULK_DIG: begin
        lim_div = LenDiv;
        lim_mod = LenMod;
      end
      PH_ARR_DIG: begin
        lim_div = ArrDiv;
        lim_mod = ArrMod;
      end
      default: begin
        lim_div = negative_q ? IntNegDiv : IntPosDiv;
        lim_mod = negative_q ? IntNegMod : IntPosMod;
      end
    endcase
  end

  assign ovf = (accum_q > lim_div) || ((accum_q == lim_div) && (dval > lim_mod));

  always_comb begin
    phase_d      = phase_q;
    cur_type_d   = cur_type_q;
    negative_d   = negative_q;
    accum_d      = accum_q;
    seen_d       = seen_q;
    bytes_left_d = bytes_left_q;
    elems_left_d = elems_left_q;
    in_array_d   = in_array_q;
    swallow_d    = swallow_q;
    res_vld_o    = 1'b0;
    res_o        = '0;
    flt          = 1'b0;
    fcode        = FLT_NONE;
    fin          = 1'b0;
    fin_type     = VT_SIMPLE;
    fin_num      = '0;

    if (en_i) begin
      swallow_d = 1'b0;
      if (!skip) begin
        unique case (phase_q)
          PH_IDLE: begin
            negative_d   = 1'b0;
            accum_d      = '0;
            seen_d       = 1'b0;
            bytes_left_d = '0;
            priority if (byte_i == CH_PLUS) begin
              cur_type_d = VT_SIMPLE;
              phase_d    = PH_SIMPLE_TXT;
            end else if (byte_i == CH_COLON) begin
              cur_type_d = VT_INTEGER;
              phase_d    = PH_INT_SIGN;
            end else if (byte_i == CH_DOLLAR) begin
              cur_type_d = VT_BULK;
              phase_d    = PH_BULK_DIG;
            end else if (!in_array_q && byte_i == CH_MINUS) begin
              cur_type_d = VT_ERROR;
              phase_d    = PH_ERR_TXT;
            end else if (!in_array_q && byte_i == CH_STAR) begin
              cur_type_d = VT_ARRAY;
              phase_d    = PH_ARR_DIG;
            end else begin
              cur_type_d = VT_SIMPLE;
              flt        = 1'b1;
              fcode      = FLT_BAD_TYPE;
            end
          end
          PH_SIMPLE_TXT: begin
            if (is_eol) begin
              priority if (!seen_q) begin
                flt   = 1'b1;
                fcode = FLT_EMPTY;
              end else if (byte_i == CH_LF) begin
                flt   = 1'b1;
                fcode = FLT_NO_CRLF;
              end else begin
                phase_d = PH_SIMPLE_LF;
              end
            end else begin
              seen_d       = 1'b1;
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_DATA;
              res_o.vtype  = VT_SIMPLE;
              res_o.data   = byte_i;
              res_o.inarr  = in_array_q;
            end
          end
          PH_SIMPLE_LF: begin
            if (byte_i != CH_LF) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              fin      = 1'b1;
              fin_type = VT_SIMPLE;
            end
          end
          PH_ERR_TXT: begin
            if (is_eol) begin
              if (!seen_q) begin
                flt   = 1'b1;
                fcode = FLT_EMPTY;
              end else begin
                fin       = 1'b1;
                fin_type  = VT_ERROR;
                swallow_d = (byte_i == CH_CR);
              end
            end else begin
              seen_d       = 1'b1;
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_DATA;
              res_o.vtype  = VT_ERROR;
              res_o.data   = byte_i;
              res_o.inarr  = in_array_q;
            end
          end
          PH_INT_SIGN, PH_INT_DIG: begin
            if (phase_q == PH_INT_SIGN && (byte_i == CH_PLUS || byte_i == CH_MINUS)) begin
              negative_d = (byte_i == CH_MINUS);
              phase_d    = PH_INT_DIG;
            end else begin
              phase_d = PH_INT_DIG;
              priority if (is_dig) begin
                if (ovf) begin
                  flt   = 1'b1;
                  fcode = FLT_OVERFLOW;
                end else begin
                  accum_d = acc_next;
                  seen_d  = 1'b1;
                end
              end else if (is_eol) begin
                if (!seen_q) begin
                  flt   = 1'b1;
                  fcode = FLT_BAD_DIGIT;
                end else begin
                  fin       = 1'b1;
                  fin_type  = VT_INTEGER;
                  fin_num   = negative_q ? (64'd0 - accum_q) : accum_q;
                  swallow_d = (byte_i == CH_CR);
                end
              end else begin
                flt   = 1'b1;
                fcode = FLT_BAD_DIGIT;
              end
            end
          end
          PH_BULK_DIG: begin
            priority if (byte_i == CH_MINUS && !seen_q) begin
              phase_d = PH_NULL_ONE;
            end else if (is_dig) begin
              if (ovf) begin
                flt   = 1'b1;
                fcode = FLT_OVERFLOW;
              end else begin
                accum_d = acc_next;
                seen_d  = 1'b1;
              end
            end else if (byte_i == CH_CR) begin
              if (!seen_q) begin
                flt   = 1'b1;
                fcode = FLT_BAD_DIGIT;
              end else begin
                bytes_left_d = accum_q[LEN_BITS-1:0];
                phase_d      = PH_BULK_HDR_LF;
              end
            end else if (byte_i == CH_LF && seen_q) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              flt   = 1'b1;
              fcode = FLT_BAD_DIGIT;
            end
          end
          PH_BULK_HDR_LF: begin
            if (byte_i != CH_LF) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              phase_d = (bytes_left_q != '0) ? PH_BULK_DATA : PH_BULK_END_CR;
            end
          end
          PH_BULK_DATA: begin
            res_vld_o    = 1'b1;
            res_o.kind   = KIND_DATA;
            res_o.vtype  = VT_BULK;
            res_o.data   = byte_i;
            res_o.inarr  = in_array_q;
            bytes_left_d = bytes_left_q - LEN_BITS'(1);
            if (bytes_left_d == '0) begin
              phase_d = PH_BULK_END_CR;
            end
          end
          PH_BULK_END_CR: begin
            if (byte_i != CH_CR) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              phase_d = PH_BULK_END_LF;
            end
          end
          PH_BULK_END_LF: begin
            if (byte_i != CH_LF) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              fin      = 1'b1;
              fin_type = VT_BULK;
              fin_num  = accum_q;
            end
          end
          PH_NULL_ONE: begin
            cur_type_d = VT_NULL;
            if (byte_i != CH_ONE) begin
              flt   = 1'b1;
              fcode = FLT_BAD_DIGIT;
            end else begin
              phase_d = PH_NULL_CR;
            end
          end
          PH_NULL_CR: begin
            if (byte_i != CH_CR) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              phase_d = PH_NULL_LF;
            end
          end
          PH_NULL_LF: begin
            if (byte_i != CH_LF) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              fin      = 1'b1;
              fin_type = VT_NULL;
            end
          end
          PH_ARR_DIG: begin
            priority if (is_dig) begin
              if (ovf) begin
                flt   = 1'b1;
                fcode = FLT_OVERFLOW;
              end else begin
                accum_d = acc_next;
                seen_d  = 1'b1;
              end
            end else if (byte_i == CH_CR) begin
              if (!seen_q) begin
                flt   = 1'b1;
                fcode = FLT_BAD_DIGIT;
              end else begin
                phase_d = PH_ARR_LF;
              end
            end else if (byte_i == CH_LF && seen_q) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              flt   = 1'b1;
              fcode = FLT_BAD_DIGIT;
            end
          end
          PH_ARR_LF: begin
            if (byte_i != CH_LF) begin
              flt   = 1'b1;
              fcode = FLT_NO_CRLF;
            end else begin
              res_vld_o    = 1'b1;
              res_o.kind   = KIND_ARRAY_HDR;
              res_o.vtype  = VT_ARRAY;
              res_o.number = accum_q;
              res_o.done   = (accum_q == '0);
              if (accum_q != '0) begin
                in_array_d   = 1'b1;
                elems_left_d = accum_q[31:0];
              end
              phase_d = PH_IDLE;
            end
          end
          default: begin
            cur_type_d = VT_SIMPLE;
            flt        = 1'b1;
            fcode      = FLT_BAD_TYPE;
          end
        endcase

        if (flt) begin
          res_vld_o    = 1'b1;
          res_o        = '0;
          res_o.kind   = KIND_FAULT;
          res_o.vtype  = cur_type_d;
          res_o.inarr  = in_array_q;
          res_o.fcode  = fcode;
          phase_d      = PH_IDLE;
          cur_type_d   = VT_SIMPLE;
          negative_d   = 1'b0;
          accum_d      = '0;
          seen_d       = 1'b0;
          bytes_left_d = '0;
          elems_left_d = '0;
          in_array_d   = 1'b0;
          swallow_d    = 1'b0;
        end else if (fin) begin
          res_vld_o    = 1'b1;
          res_o        = '0;
          res_o.kind   = KIND_DONE;
          res_o.vtype  = fin_type;
          res_o.number = fin_num;
          res_o.inarr  = in_array_q;
          res_o.done   = 1'b1;
          if (in_array_q) begin
            elems_left_d = elems_left_q - 32'd1;
            if (elems_left_d == '0) begin
              in_array_d = 1'b0;
            end else begin
              res_o.done = 1'b0;
            end
          end
          phase_d = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      cur_type_q   <= VT_SIMPLE;
      negative_q   <= 1'b0;
      accum_q      <= '0;
      seen_q       <= 1'b0;
      bytes_left_q <= '0;
      elems_left_q <= '0;
      in_array_q   <= 1'b0;
      swallow_q    <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      cur_type_q   <= cur_type_d;
      negative_q   <= negative_d;
      accum_q      <= accum_d;
      seen_q       <= seen_d;
      bytes_left_q <= bytes_left_d;
      elems_left_q <= elems_left_d;
      in_array_q   <= in_array_d;
      swallow_q    <= swallow_d;
    end
  end

endmodule

### hdl/rsp_out_stage.sv
// Result register: holds one parse result until the consumer takes it.
// Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_out_stage import rsp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     res_vld_i,
  input  rsp_res_t res_i,
  output logic     advance_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rsp_res_t res_o
);

  logic     vld_q;
  rsp_res_t res_q;

  assign advance_o   = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (advance_o) begin
      vld_q <= res_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && res_vld_i) begin
      res_q <= res_i;
    end
  end

endmodule

### hdl/resp_stream_parser_core.sv
// Top level of the RESP2 reply parser: input register, parse step, result register.
// Depends on rsp_pkg, rsp_in_stage, rsp_parse and rsp_out_stage.
`timescale 1ns / 1ps

// One received byte is accepted per cycle while the result register is empty or
// being taken, and gives at most one result word, registered in the result register.
// The rate is set by the single parse step between the input register and the
// result register, whose longest path is the 64-bit multiply-by-ten-plus-digit
// update and its overflow compare. The result register frees as soon as the
// consumer takes its word, so a full stream runs at one byte per cycle while
// out_ready_i stays high. LEN_BITS caps bulk lengths at 2^LEN_BITS-1.

module resp_stream_parser_core import rsp_pkg::*; #(
  parameter int LEN_BITS = LenBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         out_kind_o,
  output logic [2:0]         value_type_o,
  output logic [7:0]         data_byte_o,
  output logic signed [63:0] number_o,
  output logic               inside_array_o,
  output logic               message_done_o,
  output logic [2:0]         fault_code_o
);

  logic       advance;
  logic       byte_vld;
  logic [7:0] byte_q;
  logic       res_vld;
  rsp_res_t   res;
  rsp_res_t   out_res;

  rsp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .advance_i  (advance),
    .vld_o      (byte_vld),
    .byte_o     (byte_q)
  );

  rsp_parse #(
    .LEN_BITS (LEN_BITS)
  ) u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance && byte_vld),
    .byte_i    (byte_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  rsp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_vld_i   (res_vld),
    .res_i       (res),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_kind_o     = out_res.kind;
  assign value_type_o   = out_res.vtype;
  assign data_byte_o    = out_res.data;
  assign number_o       = $signed(out_res.number);
  assign inside_array_o = out_res.inarr;
  assign message_done_o = out_res.done;
  assign fault_code_o   = out_res.fcode;

endmodule

### hdl/rsp_checker.sv
// Port-level checks for the RESP2 reply parser and the bind that attaches them.
// Depends on rsp_pkg and resp_stream_parser_core.
`timescale 1ns / 1ps

module rsp_checker import rsp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         out_kind_o,
  input logic [2:0]         value_type_o,
  input logic [7:0]         data_byte_o,
  input logic signed [63:0] number_o,
  input logic               inside_array_o,
  input logic               message_done_o,
  input logic [2:0]         fault_code_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_kind_o) &&
    $stable(number_o) && $stable(data_byte_o))
    else $error("result word changed while stalled");

  a_fault_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_FAULT |->
    !message_done_o && number_o == 64'sd0 && fault_code_o != FLT_NONE)
    else $error("fault word carries value fields");

  a_data_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_DATA |->
    !message_done_o && number_o == 64'sd0 && fault_code_o == FLT_NONE &&
    (value_type_o == VT_SIMPLE || value_type_o == VT_ERROR || value_type_o == VT_BULK))
    else $error("payload word with bad fields");

  a_hdr_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_kind_o == KIND_ARRAY_HDR |->
    value_type_o == VT_ARRAY && !inside_array_o && number_o >= 64'sd0 &&
    message_done_o == (number_o == 64'sd0))
    else $error("array header with bad fields");

endmodule

bind resp_stream_parser_core rsp_checker u_rsp_checker (.*);

### tb/sv/rsp_parse_checker.sv
// Checker for the RESP2 reply parser: watches both channels, predicts each result word
// from the accepted bytes and compares it field by field. Depends on rsp_pkg.
`timescale 1ns / 1ps

module rsp_parse_checker import rsp_pkg::*; #(
  parameter int LEN_BITS = LenBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  out_kind_i,
  input  logic [2:0]  value_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [63:0] number_i,
  input  logic        inside_array_i,
  input  logic        message_done_i,
  input  logic [2:0]  fault_code_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  localparam logic [63:0] BulkCap = (LEN_BITS >= 64) ? {64{1'b1}} :
                                    (64'd1 << LEN_BITS) - 64'd1;

  rsp_phase_e  st_phase = PH_IDLE;
  rsp_vtype_e  st_vtype = VT_SIMPLE;
  logic        st_neg = 1'b0;
  logic [63:0] st_acc = '0;
  logic        st_seen = 1'b0;
  logic [63:0] st_bulk_left = '0;
  logic [31:0] st_elems = '0;
  logic        st_in_arr = 1'b0;
  logic        st_skip_lf = 1'b0;

  rsp_res_t result_words_q[$];
  int       mismatch_cnt = 0;
  int       pending_cnt = 0;

  assign fail_cnt_o = mismatch_cnt;
  assign pending_o  = pending_cnt;

  function automatic void clear_state();
    st_phase     = PH_IDLE;
    st_vtype     = VT_SIMPLE;
    st_neg       = 1'b0;
    st_acc       = '0;
    st_seen      = 1'b0;
    st_bulk_left = '0;
    st_elems     = '0;
    st_in_arr    = 1'b0;
    st_skip_lf   = 1'b0;
  endfunction

  function automatic rsp_res_t word_of(rsp_kind_e k, rsp_vtype_e t, logic [7:0] d,
                                       logic [63:0] n, logic ia, logic dn, rsp_fault_e f);
    rsp_res_t w;
    w.kind   = k;
    w.vtype  = t;
    w.data   = d;
    w.number = n;
    w.inarr  = ia;
    w.done   = dn;
    w.fcode  = f;
    return w;
  endfunction

  function automatic rsp_res_t fault_word(rsp_fault_e f);
    rsp_res_t w;
    w = word_of(KIND_FAULT, st_vtype, 8'd0, 64'd0, st_in_arr, 1'b0, f);
    clear_state();
    return w;
  endfunction

  function automatic rsp_res_t close_word(rsp_vtype_e t, logic [63:0] n);
    logic ia;
    logic dn;
    ia = st_in_arr;
    dn = 1'b1;
    if (st_in_arr) begin
      st_elems = st_elems - 32'd1;
      if (st_elems == 32'd0) st_in_arr = 1'b0;
      else dn = 1'b0;
    end
    st_phase = PH_IDLE;
    return word_of(KIND_DONE, t, 8'd0, n, ia, dn, FLT_NONE);
  endfunction

  function automatic bit take_digit(logic [63:0] lim, logic [3:0] d);
    if (st_acc > lim / 64'd10 || (st_acc == lim / 64'd10 && 64'(d) > lim % 64'd10))
      return 1'b0;
    st_acc  = st_acc * 64'd10 + 64'(d);
    st_seen = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output rsp_res_t w);
    logic        dig;
    logic [3:0]  d;
    logic [63:0] lim;
    dig = (b >= CH_ZERO && b <= CH_NINE);
    d   = 4'(b - CH_ZERO);
    w   = '0;
    if (st_skip_lf) begin
      st_skip_lf = 1'b0;
      if (b == CH_LF) return 1'b0;
    end
    case (st_phase)
      PH_IDLE: begin
        st_neg       = 1'b0;
        st_acc       = '0;
        st_seen      = 1'b0;
        st_bulk_left = '0;
        if (b == CH_PLUS) begin
          st_vtype = VT_SIMPLE;
          st_phase = PH_SIMPLE_TXT;
          return 1'b0;
        end
        if (b == CH_COLON) begin
          st_vtype = VT_INTEGER;
          st_phase = PH_INT_SIGN;
          return 1'b0;
        end
        if (b == CH_DOLLAR) begin
          st_vtype = VT_BULK;
          st_phase = PH_BULK_DIG;
          return 1'b0;
        end
        if (!st_in_arr && b == CH_MINUS) begin
          st_vtype = VT_ERROR;
          st_phase = PH_ERR_TXT;
          return 1'b0;
        end
        if (!st_in_arr && b == CH_STAR) begin
          st_vtype = VT_ARRAY;
          st_phase = PH_ARR_DIG;
          return 1'b0;
        end
        st_vtype = VT_SIMPLE;
        w = fault_word(FLT_BAD_TYPE);
        return 1'b1;
      end
      PH_SIMPLE_TXT: begin
        if (b == CH_CR || b == CH_LF) begin
          if (!st_seen) begin
            w = fault_word(FLT_EMPTY);
            return 1'b1;
          end
          if (b == CH_LF) begin
            w = fault_word(FLT_NO_CRLF);
            return 1'b1;
          end
          st_phase = PH_SIMPLE_LF;
          return 1'b0;
        end
        st_seen = 1'b1;
        w = word_of(KIND_DATA, VT_SIMPLE, b, 64'd0, st_in_arr, 1'b0, FLT_NONE);
        return 1'b1;
      end
      PH_SIMPLE_LF: begin
        if (b != CH_LF) w = fault_word(FLT_NO_CRLF);
        else w = close_word(VT_SIMPLE, 64'd0);
        return 1'b1;
      end
      PH_ERR_TXT: begin
        if (b == CH_CR || b == CH_LF) begin
          if (!st_seen) begin
            w = fault_word(FLT_EMPTY);
            return 1'b1;
          end
          w = close_word(VT_ERROR, 64'd0);
          st_skip_lf = (b == CH_CR);
          return 1'b1;
        end
        st_seen = 1'b1;
        w = word_of(KIND_DATA, VT_ERROR, b, 64'd0, st_in_arr, 1'b0, FLT_NONE);
        return 1'b1;
      end
      PH_INT_SIGN, PH_INT_DIG: begin
        if (st_phase == PH_INT_SIGN && (b == CH_PLUS || b == CH_MINUS)) begin
          st_neg   = (b == CH_MINUS);
          st_phase = PH_INT_DIG;
          return 1'b0;
        end
        st_phase = PH_INT_DIG;
        if (dig) begin
          lim = st_neg ? IntNegLimit : IntPosLimit;
          if (take_digit(lim, d)) return 1'b0;
          w = fault_word(FLT_OVERFLOW);
          return 1'b1;
        end
        if (b == CH_CR || b == CH_LF) begin
          if (!st_seen) begin
            w = fault_word(FLT_BAD_DIGIT);
            return 1'b1;
          end
          w = close_word(VT_INTEGER, st_neg ? 64'd0 - st_acc : st_acc);
          st_skip_lf = (b == CH_CR);
          return 1'b1;
        end
        w = fault_word(FLT_BAD_DIGIT);
        return 1'b1;
      end
      PH_BULK_DIG: begin
        if (b == CH_MINUS && !st_seen) begin
          st_phase = PH_NULL_ONE;
          return 1'b0;
        end
        if (dig) begin
          if (take_digit(BulkCap, d)) return 1'b0;
          w = fault_word(FLT_OVERFLOW);
          return 1'b1;
        end
        if (b == CH_CR && st_seen) begin
          st_bulk_left = st_acc;
          st_phase     = PH_BULK_HDR_LF;
          return 1'b0;
        end
        if (b == CH_LF && st_seen) w = fault_word(FLT_NO_CRLF);
        else w = fault_word(FLT_BAD_DIGIT);
        return 1'b1;
      end
      PH_BULK_HDR_LF: begin
        if (b != CH_LF) begin
          w = fault_word(FLT_NO_CRLF);
          return 1'b1;
        end
        st_phase = (st_bulk_left != 64'd0) ? PH_BULK_DATA : PH_BULK_END_CR;
        return 1'b0;
      end
      PH_BULK_DATA: begin
        w = word_of(KIND_DATA, VT_BULK, b, 64'd0, st_in_arr, 1'b0, FLT_NONE);
        st_bulk_left = st_bulk_left - 64'd1;
        if (st_bulk_left == 64'd0) st_phase = PH_BULK_END_CR;
        return 1'b1;
      end
      PH_BULK_END_CR: begin
        if (b != CH_CR) begin
          w = fault_word(FLT_NO_CRLF);
          return 1'b1;
        end
        st_phase = PH_BULK_END_LF;
        return 1'b0;
      end
      PH_BULK_END_LF: begin
        if (b != CH_LF) w = fault_word(FLT_NO_CRLF);
        else w = close_word(VT_BULK, st_acc);
        return 1'b1;
      end
      PH_NULL_ONE: begin
        st_vtype = VT_NULL;
        if (b != CH_ONE) begin
          w = fault_word(FLT_BAD_DIGIT);
          return 1'b1;
        end
        st_phase = PH_NULL_CR;
        return 1'b0;
      end
      PH_NULL_CR: begin
        if (b != CH_CR) begin
          w = fault_word(FLT_NO_CRLF);
          return 1'b1;
        end
        st_phase = PH_NULL_LF;
        return 1'b0;
      end
      PH_NULL_LF: begin
        if (b != CH_LF) w = fault_word(FLT_NO_CRLF);
        else w = close_word(VT_NULL, 64'd0);
        return 1'b1;
      end
      PH_ARR_DIG: begin
        if (dig) begin
          if (take_digit(ArrLimit, d)) return 1'b0;
          w = fault_word(FLT_OVERFLOW);
          return 1'b1;
        end
        if (b == CH_CR && st_seen) begin
          st_phase = PH_ARR_LF;
          return 1'b0;
        end
        if (b == CH_LF && st_seen) w = fault_word(FLT_NO_CRLF);
        else w = fault_word(FLT_BAD_DIGIT);
        return 1'b1;
      end
      PH_ARR_LF: begin
        if (b != CH_LF) begin
          w = fault_word(FLT_NO_CRLF);
          return 1'b1;
        end
        w = word_of(KIND_ARRAY_HDR, VT_ARRAY, 8'd0, st_acc, 1'b0, st_acc == 64'd0, FLT_NONE);
        if (st_acc != 64'd0) begin
          st_in_arr = 1'b1;
          st_elems  = st_acc[31:0];
        end
        st_phase = PH_IDLE;
        return 1'b1;
      end
      default: begin
        st_vtype = VT_SIMPLE;
        w = fault_word(FLT_BAD_TYPE);
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    rsp_res_t want;
    if (!rst_ni) begin
      clear_state();
      result_words_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (result_words_q.size() == 0) begin
          $error("result word with nothing expected: kind %0d", out_kind_i);
          mismatch_cnt++;
        end else begin
          want = result_words_q.pop_front();
          check_field("out_kind", 64'(want.kind), 64'(out_kind_i));
          check_field("value_type", 64'(want.vtype), 64'(value_type_i));
          check_field("data_byte", 64'(want.data), 64'(data_byte_i));
          check_field("number", want.number, number_i);
          check_field("inside_array", 64'(want.inarr), 64'(inside_array_i));
          check_field("message_done", 64'(want.done), 64'(message_done_i));
          check_field("fault_code", 64'(want.fcode), 64'(fault_code_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_byte_i, want)) result_words_q.push_back(want);
      end
    end
    pending_cnt = result_words_q.size();
  end

endmodule

### tb/sv/tb.sv
// Testbench top for resp_stream_parser_core: drives reply byte streams with random
// gaps and back-pressure, and gives the verdict. Also needs rsp_pkg and rsp_parse_checker.
`timescale 1ns / 1ps

module tb import rsp_pkg::*; ();

  localparam int RandBytes  = 850;
  localparam int StallLimit = 2000;
  localparam int HoldCycles = 250;
  localparam int NumOdd     = 30;

  typedef enum int {
    R_SIMPLE, R_ERROR, R_INT, R_BULK, R_NULL, R_ARRAY
  } reply_form_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_byte = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  out_kind;
  logic [2:0]  value_type;
  logic [7:0]  data_byte;
  logic [63:0] number;
  logic        inside_array;
  logic        message_done;
  logic [2:0]  fault_code;
  int          fails;
  int          pending;

  bit          idle_on = 1'b1;
  bit          rx_hold_go = 1'b0;
  int          stall_cycles = 0;
  logic [7:0]  reply_q[$];

  string odd_forms [0:NumOdd-1] = '{
    "+\015\012", "-\015\012", "-\012", ":\015\012", ":-\012", ":+-1\015\012",
    ":12a\015\012", ":9223372036854775808\015\012", ":-9223372036854775809\012",
    "$\015\012", "$5\012", "$-\015\012", "$-2\015\012", "$-1\012", "$-1\015X",
    "$2\015\012ab\012", "$2\015\012ab\015X", "$2\015X", "$4294967296\015\012",
    "$4294967295X", "*\015\012", "*3\012", "*x", "*4294967296\015\012",
    "*4294967295\015\012-", "+ab\012", "+ab\015X", "*1\015\012*",
    "$01\015\012z\015\012", ":-9223372036854775808\015"
  };

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  resp_stream_parser_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .in_byte_i      (in_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .out_kind_o     (out_kind),
    .value_type_o   (value_type),
    .data_byte_o    (data_byte),
    .number_o       (number),
    .inside_array_o (inside_array),
    .message_done_o (message_done),
    .fault_code_o   (fault_code)
  );

  rsp_parse_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_byte_i      (in_byte),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_kind_i     (out_kind),
    .value_type_i   (value_type),
    .data_byte_i    (data_byte),
    .number_i       (number),
    .inside_array_i (inside_array),
    .message_done_i (message_done),
    .fault_code_i   (fault_code),
    .fail_cnt_o     (fails),
    .pending_o      (pending)
  );

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : rx_side
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (rx_hold_go) begin
        rx_hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      out_ready <= !(idle_on && $urandom_range(99) < 19);
    end
  end

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) reply_q.push_back(s[i]);
  endfunction

  function automatic void add_text(int n);
    logic [7:0] c;
    repeat (n) begin
      do c = 8'($urandom); while (c == CH_CR || c == CH_LF);
      reply_q.push_back(c);
    end
  endfunction

  function automatic void add_eol();
    case ($urandom_range(2))
      0: reply_q.push_back(CH_CR);
      1: reply_q.push_back(CH_LF);
      default: add_str("\015\012");
    endcase
  endfunction

  function automatic void add_int();
    longint v;
    v = longint'({$urandom, $urandom}) >>> $urandom_range(63);
    case ($urandom_range(7))
      0: add_str(":9223372036854775807");
      1: add_str(":-9223372036854775808");
      2: add_str($sformatf(":+%0d", v & IntPosLimit));
      default: add_str($sformatf(":%0d", v));
    endcase
    add_eol();
  endfunction

  function automatic reply_form_e pick_elem();
    reply_form_e k;
    k = reply_form_e'($urandom_range(R_NULL));
    if (k == R_ERROR) k = R_SIMPLE;
    return k;
  endfunction

  function automatic void add_value(reply_form_e k);
    int n;
    case (k)
      R_SIMPLE: begin
        add_str("+");
        add_text($urandom_range(1, 6));
        add_str("\015\012");
      end
      R_ERROR: begin
        add_str("-");
        add_text($urandom_range(1, 6));
        add_eol();
      end
      R_INT: add_int();
      R_BULK: begin
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(8);
        add_str($sformatf("$%0d\015\012", n));
        repeat (n) reply_q.push_back(8'($urandom));
        add_str("\015\012");
      end
      R_NULL: add_str("$-1\015\012");
      default: begin
        n = $urandom_range(4);
        add_str($sformatf("*%0d\015\012", n));
        repeat (n) add_value(pick_elem());
      end
    endcase
  endfunction

  function automatic void add_broken();
    int at;
    case ($urandom_range(5))
      0: repeat ($urandom_range(1, 3)) reply_q.push_back(8'($urandom));
      1, 2: add_str(odd_forms[$urandom_range(NumOdd - 1)]);
      3: begin
        add_str("*2\015\012");
        add_value(pick_elem());
        reply_q.push_back($urandom_range(1) ? CH_MINUS : CH_STAR);
      end
      default: begin
        add_value(reply_form_e'($urandom_range(R_ARRAY)));
        at = $urandom_range(reply_q.size() - 1);
        case ($urandom_range(6))
          0: reply_q[at] = CH_CR;
          1: reply_q[at] = CH_LF;
          2: reply_q[at] = CH_ONE;
          3: reply_q[at] = CH_MINUS;
          4: reply_q[at] = CH_PLUS;
          5: reply_q[at] = 8'($urandom);
          default: if (reply_q.size() > 1) reply_q.delete(reply_q.size() - 1);
        endcase
      end
    endcase
  endfunction

  function automatic void add_reply();
    int r;
    r = $urandom_range(99);
    if (r < 12) add_value(R_SIMPLE);
    else if (r < 20) add_value(R_ERROR);
    else if (r < 34) add_value(R_INT);
    else if (r < 48) add_value(R_BULK);
    else if (r < 53) add_value(R_NULL);
    else if (r < 78) add_value(R_ARRAY);
    else add_broken();
  endfunction

  task automatic send_word(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_reply_bytes();
    while (reply_q.size() != 0) send_word(reply_q.pop_front());
  endtask

  initial begin : stimulus
    int  sent;
    bit  paused;
    bit  held;
    sent   = 0;
    paused = 1'b0;
    held   = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    add_str("+");
    reply_q.push_back(8'h00);
    reply_q.push_back(8'hFF);
    add_str("\015\012-e\012:+0\015\012$0\015\012\015\012$-1\015\012*0\015\012");
    reply_q.push_back(8'hFF);
    send_reply_bytes();

    while (sent < RandBytes) begin
      if (sent >= 200 && !held) begin
        held       = 1'b1;
        rx_hold_go = 1'b1;
      end
      idle_on = !(sent >= 500 && sent < 650);
      if (sent >= 350 && !paused) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
      end
      add_reply();
      sent += reply_q.size();
      send_reply_bytes();
    end

    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fails == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
